// ===== sv/rrtt_pkg.sv =====
// ----------------------------------------------------------------------------
// rrtt_pkg: shared definitions for the round-robin task table
// Field widths of the stream payloads, action codes and status codes.
// ----------------------------------------------------------------------------
package rrtt_pkg;

    // Fixed payload field widths.
    localparam int SEL_W  = 16;
    localparam int TID_W  = 16;
    localparam int SLOT_W = 4;
    localparam int LIVE_W = 5;
    localparam int STAT_W = 3;
    localparam int ACT_W  = 2;

    // Actions carried in the input tuser.
    localparam logic [ACT_W-1:0] ACT_TICK     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD      = 2'd1;
    localparam logic [ACT_W-1:0] ACT_KILL_ID  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_KILL_CUR = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd1;
    localparam logic [STAT_W-1:0] STAT_LAST_TASK = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NO_TASKS  = 3'd4;

endpackage

// ===== sv/rrtt_cell.sv =====
// ----------------------------------------------------------------------------
// rrtt_cell: one table entry of the rotating task ring
// Holds one packed entry. It takes its neighbor's entry on a shift and can
// be loaded directly when the ring stands still.
// ----------------------------------------------------------------------------
module rrtt_cell #(
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              shift_en,
    input  logic [DATA_W-1:0] shift_in,
    input  logic              load_en,
    input  logic [DATA_W-1:0] load_in,
    output logic [DATA_W-1:0] entry_q
);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;

    // A shift has priority; a direct load only happens while the ring rests.
    always_comb begin
        entry_next = entry_reg;
        if (shift_en) begin
            entry_next = shift_in;
        end else if (load_en) begin
            entry_next = load_in;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_q = entry_reg;

endmodule

// ===== sv/round_robin_task_table.sv =====
// Passes: tick and add take a capture pass from input transfer to result valid; kill by
// id takes a capture and a write pass, kill of the current task a capture, a search and
// a write pass. Each pass is one full turn of the entry ring, which shows one entry per
// cycle at the head cell. Items are served one by one; a stalled result delays the next.
// Reset (aresetn low, synchronous): one task, id 0 with selector 0, count 1, index 0.
// Other entries are left as they are; there is no clearing pass.
// ----------------------------------------------------------------------------
// round_robin_task_table: round-robin task table on a rotating ring of cells
// Ticks, adds and kills are served by rotating the table past a head cell,
// where the sequencer captures, searches and rewrites entries.
// ----------------------------------------------------------------------------
module round_robin_task_table
    import rrtt_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int ID_BITS   = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration: boot_selector register.
    input  logic              cfg_we,
    input  logic [SEL_W-1:0]  cfg_wdata,
    // Input stream.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [15:0] task_id, [31:16] task_selector
    input  logic [ACT_W-1:0]  s_tuser,   // [1:0] action
    // Result stream.
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata    // [15:0] next_selector, [19:16] current_slot,
                                         // [24:20] live_count, [25] reschedule,
                                         // [28:26] status, [31:29] zero
);

    localparam int IDX_W  = $clog2(MAX_TASKS);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int DATA_W = ID_BITS + SEL_W;
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_TASKS - 1);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_TASKS);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CAP  = 3'd1;
    localparam logic [2:0] ST_SRCH = 3'd2;
    localparam logic [2:0] ST_WR   = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic [ACT_W-1:0]  act_reg, act_next;
    logic [ID_BITS-1:0] key_reg, key_next;
    logic [DATA_W-1:0] add_entry_reg, add_entry_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic              started_reg, started_next;
    logic [SEL_W-1:0]  cur_sel_reg, cur_sel_next;
    logic [SEL_W-1:0]  zero_sel_reg, zero_sel_next;
    logic [DATA_W-1:0] last_entry_reg, last_entry_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [31:0]       m_tdata_reg, m_tdata_next;

    logic [DATA_W-1:0] ring_q [MAX_TASKS];
    logic [DATA_W-1:0] wrap_data;
    logic              shift_en;
    logic              head_load;
    logic [DATA_W-1:0] head_load_data;
    logic [ID_BITS-1:0] head_id;
    logic [SEL_W-1:0]  head_sel;
    logic [CNT_W-1:0]  step_ext;
    logic              in_xfer;
    logic              search_en;
    logic              kill_ok;

    // Result fields of the item being finished.
    logic [SEL_W-1:0]  res_sel;
    logic [IDX_W-1:0]  res_cur;
    logic [CNT_W-1:0]  res_count;
    logic              res_resched;
    logic [STAT_W-1:0] res_status;
    logic [CNT_W-1:0]  kill_count;
    logic [IDX_W-1:0]  kill_cur;

    // Index normalization and tick advance at input transfer.
    logic [IDX_W-1:0]  cur_norm;
    logic [CNT_W-1:0]  tick_inc;
    logic [IDX_W-1:0]  tick_idx;

    assign in_xfer  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The ring stands still during reset so that entry zero is restored in place.
    assign shift_en = aresetn &&
                      ((state_reg == ST_CAP) || (state_reg == ST_SRCH) || (state_reg == ST_WR));
    assign head_id  = ring_q[0][DATA_W-1:SEL_W];
    assign head_sel = ring_q[0][SEL_W-1:0];
    assign step_ext = CNT_W'(step_reg);
    assign kill_ok  = found_reg && (count_reg > CNT_W'(1));

    assign search_en = ((state_reg == ST_CAP) && (act_reg == ACT_KILL_ID)) ||
                       (state_reg == ST_SRCH);

    // Entry that re-enters the ring at its tail: a new task, a moved last
    // task, or the head entry unchanged.
    always_comb begin
        wrap_data = ring_q[0];
        if ((state_reg == ST_CAP) && (act_reg == ACT_ADD) && (step_ext == count_reg)) begin
            wrap_data = add_entry_reg;
        end else if ((state_reg == ST_WR) && kill_ok && (step_reg == slot_reg)) begin
            wrap_data = last_entry_reg;
        end
    end

    // Reset restores entry zero; a boot selector write before the first item
    // also updates it.
    always_comb begin
        head_load      = 1'b0;
        head_load_data = ring_q[0];
        if (!aresetn) begin
            head_load      = 1'b1;
            head_load_data = '0;
        end else if (cfg_we && !started_reg) begin
            head_load      = 1'b1;
            head_load_data = {head_id, cfg_wdata};
        end
    end

    // The ring of cells; each cell takes its upper neighbor's entry.
    for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
        if (i == MAX_TASKS - 1) begin : g_tail
            rrtt_cell #(.DATA_W(DATA_W)) u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .shift_in (wrap_data),
                .load_en  (1'b0),
                .load_in  (wrap_data),
                .entry_q  (ring_q[i])
            );
        end else if (i == 0) begin : g_head
            rrtt_cell #(.DATA_W(DATA_W)) u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .shift_in (ring_q[i+1]),
                .load_en  (head_load),
                .load_in  (head_load_data),
                .entry_q  (ring_q[i])
            );
        end else begin : g_mid
            rrtt_cell #(.DATA_W(DATA_W)) u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .shift_in (ring_q[i+1]),
                .load_en  (1'b0),
                .load_in  (ring_q[i+1]),
                .entry_q  (ring_q[i])
            );
        end
    end

    // Current index as the item starts, and where a tick moves it.
    always_comb begin
        cur_norm = (CNT_W'(cur_reg) >= count_reg) ? '0 : cur_reg;
        tick_inc = CNT_W'(cur_norm) + CNT_W'(1);
        if (count_reg == '0) begin
            tick_idx = cur_norm;
        end else if (tick_inc >= count_reg) begin
            tick_idx = '0;
        end else begin
            tick_idx = IDX_W'(tick_inc);
        end
    end

    // Outcome of a kill that removes a task.
    always_comb begin
        kill_count = count_reg - CNT_W'(1);
        kill_cur   = (CNT_W'(cur_reg) >= kill_count) ? '0 : cur_reg;
    end

    // Result of the finished item.
    always_comb begin
        res_sel     = cur_sel_reg;
        res_cur     = cur_reg;
        res_count   = count_reg;
        res_resched = 1'b0;
        res_status  = STAT_OK;
        case (act_reg)
            ACT_TICK: begin
                if (count_reg == '0) begin
                    res_status = STAT_NO_TASKS;
                    res_sel    = '0;
                end
            end
            ACT_ADD: begin
                if (count_reg >= CNT_MAX) begin
                    res_status = STAT_FULL;
                end else begin
                    res_count = count_reg + CNT_W'(1);
                end
            end
            ACT_KILL_ID, ACT_KILL_CUR: begin
                if ((act_reg == ACT_KILL_CUR) && (count_reg == '0)) begin
                    res_status = STAT_NO_TASKS;
                    res_sel    = '0;
                end else if (!found_reg) begin
                    res_status = STAT_NOT_FOUND;
                end else if (!kill_ok) begin
                    res_status = STAT_LAST_TASK;
                end else begin
                    res_count   = kill_count;
                    res_cur     = kill_cur;
                    res_resched = 1'b1;
                    if (kill_cur == slot_reg) begin
                        res_sel = last_entry_reg[SEL_W-1:0];
                    end else if (kill_cur != cur_reg) begin
                        res_sel = zero_sel_reg;
                    end
                end
            end
            default: begin
                res_status = STAT_OK;
            end
        endcase
    end

    // Sequencer: capture pass, optional search pass, optional write pass.
    always_comb begin
        state_next      = state_reg;
        step_next       = step_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        add_entry_next  = add_entry_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        started_next    = started_reg;
        cur_sel_next    = cur_sel_reg;
        zero_sel_next   = zero_sel_reg;
        last_entry_next = last_entry_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;

        // Result register drains independently of the work in progress.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    started_next   = 1'b1;
                    act_next       = s_tuser;
                    key_next       = ID_BITS'(s_tdata[TID_W-1:0]);
                    add_entry_next = {ID_BITS'(s_tdata[TID_W-1:0]),
                                      s_tdata[TID_W+SEL_W-1:TID_W]};
                    cur_next       = (s_tuser == ACT_TICK) ? tick_idx : cur_norm;
                    found_next     = 1'b0;
                    slot_next      = '0;
                    step_next      = '0;
                    state_next     = ST_CAP;
                end
            end
            ST_CAP, ST_SRCH, ST_WR: begin
                if (state_reg == ST_CAP) begin
                    if (step_reg == cur_reg) begin
                        cur_sel_next = head_sel;
                        if (act_reg == ACT_KILL_CUR) begin
                            key_next = head_id;
                        end
                    end
                    if (step_reg == '0) begin
                        zero_sel_next = head_sel;
                    end
                    if (step_ext == count_reg - CNT_W'(1)) begin
                        last_entry_next = ring_q[0];
                    end
                end
                if (search_en && !found_reg && (step_ext < count_reg) &&
                    (head_id == key_reg)) begin
                    found_next = 1'b1;
                    slot_next  = step_reg;
                end
                if (step_reg == LAST_STEP) begin
                    step_next = '0;
                    case (state_reg)
                        ST_CAP: begin
                            if (act_reg == ACT_KILL_ID) begin
                                state_next = ST_WR;
                            end else if (act_reg == ACT_KILL_CUR) begin
                                state_next = ST_SRCH;
                            end else begin
                                state_next = ST_DONE;
                            end
                        end
                        ST_SRCH: begin
                            state_next = ST_WR;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end else begin
                    step_next = step_reg + IDX_W'(1);
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    count_next    = res_count;
                    cur_next      = res_cur;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, res_status, res_resched,
                                     LIVE_W'(res_count), SLOT_W'(res_cur), res_sel};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            count_reg    <= CNT_W'(1);
            cur_reg      <= '0;
            started_reg  <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            count_reg    <= count_next;
            cur_reg      <= cur_next;
            started_reg  <= started_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        act_reg        <= act_next;
        key_reg        <= key_next;
        add_entry_reg  <= add_entry_next;
        cur_sel_reg    <= cur_sel_next;
        zero_sel_reg   <= zero_sel_next;
        last_entry_reg <= last_entry_next;
        slot_reg       <= slot_next;
        m_tdata_reg    <= m_tdata_next;
    end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the round-robin task table
// Drives ticks, adds and kills on the input stream, predicts each result from
// a behavioral copy of the table, and compares every result field by field.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rrtt_pkg::*;

    localparam int MAX_TASKS   = 16;
    localparam int TAIL_CYCLES = 3 * MAX_TASKS + 10;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    // Result word as carried on m_tdata, lowest field last.
    typedef struct packed {
        logic [2:0]        pad;
        logic [STAT_W-1:0] status;
        logic              reschedule;
        logic [LIVE_W-1:0] live_count;
        logic [SLOT_W-1:0] current_slot;
        logic [SEL_W-1:0]  next_selector;
    } sched_result_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_we;
    logic [SEL_W-1:0]  cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;   // [15:0] task_id, [31:16] task_selector
    logic [ACT_W-1:0]  s_tuser;   // [1:0] action
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;   // [15:0] next_selector, [19:16] current_slot,
                                  // [24:20] live_count, [25] reschedule,
                                  // [28:26] status, [31:29] zero

    // Behavioral copy of the task table.
    logic [TID_W-1:0] task_ids  [MAX_TASKS];
    logic [SEL_W-1:0] task_sels [MAX_TASKS];
    int unsigned      live_tasks;
    int unsigned      cur_slot;
    bit               sched_started;

    sched_result_t    pending_results [$];
    int               errors;
    int               results_checked;
    int               sent_by_action [4];
    int               status_seen [8];
    int               quiet_cycles;
    int               hold_request;
    bit               tx_idle_on;
    bit               rx_idle_on;

    round_robin_task_table #(
        .MAX_TASKS (MAX_TASKS),
        .ID_BITS   (16)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Removes the lowest slot holding tid by moving the last entry into it.
    function automatic logic [STAT_W-1:0] remove_task(input logic [TID_W-1:0] tid,
                                                      output logic resched);
        int i;
        int slot;
        slot = -1;
        resched = 1'b0;
        for (i = 0; i < live_tasks; i++) begin
            if (slot < 0 && task_ids[i] == tid) begin
                slot = i;
            end
        end
        if (slot < 0) begin
            return STAT_NOT_FOUND;
        end
        if (live_tasks <= 1) begin
            return STAT_LAST_TASK;
        end
        task_ids[slot]  = task_ids[live_tasks - 1];
        task_sels[slot] = task_sels[live_tasks - 1];
        live_tasks--;
        // A current index past the shrunken table wraps to the start.
        if (cur_slot >= live_tasks) begin
            cur_slot = 0;
        end
        resched = 1'b1;
        return STAT_OK;
    endfunction

    // Applies one action to the table copy and returns the result it yields.
    function automatic sched_result_t predict_schedule(input logic [ACT_W-1:0] act,
                                                       input logic [TID_W-1:0] tid,
                                                       input logic [SEL_W-1:0] tsel);
        sched_result_t r;
        logic          resched;
        r = '0;
        resched = 1'b0;
        sched_started = 1'b1;
        if (cur_slot >= live_tasks) begin
            cur_slot = 0;
        end
        case (act)
            ACT_TICK: begin
                if (live_tasks == 0) begin
                    r.status = STAT_NO_TASKS;
                end else begin
                    cur_slot = (cur_slot + 1) % live_tasks;
                end
            end
            ACT_ADD: begin
                if (live_tasks >= MAX_TASKS) begin
                    r.status = STAT_FULL;
                end else begin
                    task_ids[live_tasks]  = tid;
                    task_sels[live_tasks] = tsel;
                    live_tasks++;
                end
            end
            ACT_KILL_ID: begin
                r.status = remove_task(tid, resched);
            end
            default: begin
                if (live_tasks == 0) begin
                    r.status = STAT_NO_TASKS;
                end else begin
                    r.status = remove_task(task_ids[cur_slot], resched);
                end
            end
        endcase
        r.reschedule    = resched;
        r.next_selector = (live_tasks != 0) ? task_sels[cur_slot] : '0;
        r.current_slot  = cur_slot[SLOT_W-1:0];
        r.live_count    = live_tasks[LIVE_W-1:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    // Result checker: every result transfer is matched with the oldest expectation.
    always @(posedge aclk) begin
        sched_result_t got;
        sched_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: tdata=%h", m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("next_selector", want.next_selector, got.next_selector);
                check_field("current_slot", want.current_slot, got.current_slot);
                check_field("live_count", want.live_count, got.live_count);
                check_field("reschedule", want.reschedule, got.reschedule);
                check_field("status", want.status, got.status);
                check_field("pad", want.pad, got.pad);
                status_seen[want.status]++;
                results_checked++;
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: no transfer for %0d cycles", quiet_cycles);
            $display("tb_top: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result sink: random stalls, plus a long hold-off when one is requested.
    initial begin : result_sink
        int hold;
        hold = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold = hold_request;
                hold_request = 0;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(rx_idle_on && $urandom_range(99) < 14);
            end
        end
    end

    // Offers one item and waits for its transfer; returns at a falling edge
    // with tvalid still high, so that back-to-back items can follow without a gap.
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [TID_W-1:0] tid,
                             input logic [SEL_W-1:0] tsel);
        while (tx_idle_on && $urandom_range(99) < 14) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {tsel, tid};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        pending_results.push_back(predict_schedule(act, tid, tsel));
        sent_by_action[act]++;
        @(negedge aclk);
    endtask

    // Lets the table finish all outstanding work.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    // Before the first item a write also seeds the selector of entry zero.
    task automatic write_boot_selector(input logic [SEL_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        if (!sched_started) begin
            task_sels[0] = value;
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Boot selector written several times before start, then once after.
    task automatic test_boot_selector();
        write_boot_selector(16'h0000);
        write_boot_selector(16'h5A5A);
        write_boot_selector(16'hFFFF);
        send_item(ACT_TICK, 16'h0000, 16'h0000);
        wait_drained();
        write_boot_selector(16'h1234);
        send_item(ACT_TICK, 16'hFFFF, 16'hFFFF);
    endtask

    // With a single task left, kills are refused; unknown ids are reported.
    task automatic test_last_task();
        send_item(ACT_KILL_CUR, 16'h0000, 16'h0000);
        send_item(ACT_KILL_ID, 16'h0000, 16'hFFFF);
        send_item(ACT_KILL_ID, 16'hFFFF, 16'h0000);
    endtask

    // Fills the table with extreme and duplicate ids, then overflows it.
    task automatic test_table_full();
        int k;
        logic [TID_W-1:0] tid;
        send_item(ACT_ADD, 16'hFFFF, 16'h0000);
        send_item(ACT_ADD, 16'h0000, 16'hFFFF);
        for (k = 0; k < MAX_TASKS - 3; k++) begin
            tid = 16'(k * 16'h1235 + 16'h0101);
            send_item(ACT_ADD, tid, ~tid);
        end
        send_item(ACT_ADD, 16'hABCD, 16'h4321);
    endtask

    // Kill of a duplicated id, a rotation, a kill of the current task and a kill of id FFFF.
    task automatic test_kill_paths();
        send_item(ACT_KILL_ID, 16'h0000, 16'h0000);
        send_item(ACT_TICK, 16'h0000, 16'h0000);
        send_item(ACT_KILL_CUR, 16'h0000, 16'h0000);
        send_item(ACT_KILL_ID, 16'hFFFF, 16'h0000);
    endtask

    // Mostly well-formed traffic that steers the table size toward a moving
    // target, so that both the full table and the single task recur.
    task automatic test_random_traffic(input int n_items);
        int k;
        int goal;
        int pick;
        bit grow;
        logic [ACT_W-1:0] act;
        logic [TID_W-1:0] tid;
        logic [SEL_W-1:0] tsel;
        goal = MAX_TASKS / 2;
        for (k = 0; k < n_items; k++) begin
            if (k % 64 == 0) begin
                pick = $urandom_range(3);
                goal = (pick == 0) ? 1 :
                       (pick == 1) ? MAX_TASKS : $urandom_range(2, MAX_TASKS - 1);
            end
            tid  = TID_W'($urandom);
            tsel = SEL_W'($urandom);
            pick = $urandom_range(99);
            grow = (live_tasks < goal) ? 1'b1 :
                   (live_tasks > goal) ? 1'b0 : 1'($urandom_range(1));
            if (pick < 8) begin
                act = ACT_W'($urandom_range(3));
            end else if (pick < 35) begin
                act = ACT_TICK;
            end else if (grow) begin
                act = ACT_ADD;
                if ($urandom_range(3) == 0) begin
                    tid = task_ids[$urandom_range(live_tasks - 1)];
                end
            end else begin
                act = $urandom_range(1) ? ACT_KILL_ID : ACT_KILL_CUR;
                tid = task_ids[$urandom_range(live_tasks - 1)];
            end
            send_item(act, tid, tsel);
        end
    endtask

    // Both sides run without idle cycles.
    task automatic test_steady_stream(input int n_items);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_traffic(n_items);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // The sink holds off while items keep coming, so the input must stall.
    task automatic test_backpressure(input int n_items);
        tx_idle_on = 1'b0;
        hold_request = HOLD_CYCLES;
        test_random_traffic(n_items);
        tx_idle_on = 1'b1;
    endtask

    // Test sequence.
    initial begin
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = ACT_TICK;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_request    = 0;
        errors          = 0;
        results_checked = 0;
        quiet_cycles    = 0;
        foreach (task_ids[i]) begin
            task_ids[i]  = '0;
            task_sels[i] = '0;
        end
        live_tasks    = 1;
        cur_slot      = 0;
        sched_started = 1'b0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_boot_selector();
        test_last_task();
        test_table_full();
        test_kill_paths();
        wait_drained();
        write_boot_selector(16'h0000);
        test_random_traffic(700);
        wait_drained();
        write_boot_selector(16'hFFFF);
        test_steady_stream(300);
        wait_drained();
        write_boot_selector(16'($urandom));
        test_backpressure(40);
        test_random_traffic(460);

        // Drain and allow for any late, unexpected result.
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            errors++;
        end

        $display("tb_top: %0d checked: %0d ticks, %0d adds, %0d id kills, %0d current kills",
                 results_checked, sent_by_action[ACT_TICK], sent_by_action[ACT_ADD],
                 sent_by_action[ACT_KILL_ID], sent_by_action[ACT_KILL_CUR]);
        $display("tb_top: refusals seen: %0d full table, %0d last task, %0d unknown id",
                 status_seen[STAT_FULL], status_seen[STAT_LAST_TASK],
                 status_seen[STAT_NOT_FOUND]);
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
